[rtl/core/hmrf_pkg.sv]
// Package for the HID message report framer: report geometry, header byte
// positions, the sequencer phase type and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package hmrf_pkg;

    localparam int REPORT_BYTES = 64;
    localparam int OFFSET_W     = $clog2(REPORT_BYTES);

    // Header byte positions within a report header.
    localparam int          HDR_IDX_W      = 3;
    localparam logic [2:0]  HDR_CH0_IDX    = 3'd0;
    localparam logic [2:0]  HDR_CH1_IDX    = 3'd1;
    localparam logic [2:0]  HDR_CH2_IDX    = 3'd2;
    localparam logic [2:0]  HDR_CH3_IDX    = 3'd3;
    localparam logic [2:0]  HDR_CMD_IDX    = 3'd4;
    localparam logic [2:0]  HDR_SEQ_IDX    = 3'd4;
    localparam logic [2:0]  HDR_LEN_HI_IDX = 3'd5;
    localparam logic [2:0]  HDR_LEN_LO_IDX = 3'd6;
    localparam logic [2:0]  HDR_INIT_LAST  = HDR_LEN_LO_IDX;
    localparam logic [2:0]  HDR_CONT_LAST  = HDR_SEQ_IDX;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_NEW,
        PH_HEAD,
        PH_DATA,
        PH_PAD
    } phase_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_of_message;
        logic        last_of_message;
        logic        empty_message;
        logic [31:0] channel_id;
        logic [7:0]  command;
        logic [15:0] message_length;
    } item_t;

    typedef struct packed {
        phase_t                phase;
        logic [HDR_IDX_W-1:0]  hdr_idx;
        logic                  hdr_first;
        logic [OFFSET_W-1:0]   report_offset;
        logic                  message_started;
        logic [7:0]            sequence_count;
        logic [31:0]           held_channel;
    } frame_state_t;

    typedef struct packed {
        logic       emit;
        logic       done;
        logic [7:0] report_byte;
        logic       report_end;
        logic       message_end;
    } step_out_t;

endpackage

[rtl/core/hmrf_step.sv]
// Combinational step of the framer: from the held item and the framing state
// it picks the next report byte, its end marks and the next framing state.
// Depends on hmrf_pkg.
`timescale 1ns / 1ps

module hmrf_step (
    input  hmrf_pkg::item_t        item,
    input  hmrf_pkg::frame_state_t st,
    output hmrf_pkg::step_out_t    res,
    output hmrf_pkg::frame_state_t nxt
);
    import hmrf_pkg::*;

    logic                  start_msg;
    phase_t                eff_phase;
    logic [HDR_IDX_W-1:0]  eff_idx;
    logic                  eff_first;
    logic [OFFSET_W-1:0]   cur_off;
    logic                  rend;
    logic [7:0]            hdr_byte;
    logic [31:0]           ch_src;

    always_comb
    begin
        start_msg = (st.phase == PH_NEW) && (item.empty_message || item.first_of_message);

        eff_phase = st.phase;
        eff_idx   = st.hdr_idx;
        eff_first = st.hdr_first;
        if (st.phase == PH_NEW)
        begin
            eff_idx = HDR_CH0_IDX;
            if (start_msg)
            begin
                eff_phase = PH_HEAD;
                eff_first = 1'b1;
            end
            else if (!st.message_started)
            begin
                // Data outside a message is dropped without output.
                eff_phase = PH_IDLE;
                eff_first = 1'b0;
            end
            else if (st.report_offset == '0)
            begin
                eff_phase = PH_HEAD;
                eff_first = 1'b0;
            end
            else
            begin
                eff_phase = PH_DATA;
                eff_first = 1'b0;
            end
        end

        cur_off = start_msg ? '0 : st.report_offset;
        rend    = (cur_off == OFFSET_W'(REPORT_BYTES - 1));

        // The first header always belongs to the item in hand, so its fields
        // come straight from the item rather than the held copy.
        ch_src = eff_first ? item.channel_id : st.held_channel;
        case (eff_idx)
            HDR_CH0_IDX:    hdr_byte = ch_src[7:0];
            HDR_CH1_IDX:    hdr_byte = ch_src[15:8];
            HDR_CH2_IDX:    hdr_byte = ch_src[23:16];
            HDR_CH3_IDX:    hdr_byte = ch_src[31:24];
            HDR_CMD_IDX:    hdr_byte = eff_first ? item.command : st.sequence_count;
            HDR_LEN_HI_IDX: hdr_byte = item.message_length[15:8];
            HDR_LEN_LO_IDX: hdr_byte = item.message_length[7:0];
            default:        hdr_byte = 8'h00;
        endcase

        nxt = st;
        res = '0;
        res.report_end = rend;

        if (start_msg)
        begin
            nxt.held_channel    = item.channel_id;
            nxt.sequence_count  = 8'h00;
            nxt.message_started = !item.empty_message;
        end

        case (eff_phase)
            PH_HEAD:
            begin
                res.emit        = 1'b1;
                res.report_byte = hdr_byte;
                if ((eff_first && eff_idx == HDR_INIT_LAST) ||
                    (!eff_first && eff_idx == HDR_CONT_LAST))
                begin
                    nxt.phase = item.empty_message ? PH_PAD : PH_DATA;
                end
                else
                begin
                    nxt.phase = PH_HEAD;
                end
                nxt.hdr_idx   = eff_idx + HDR_IDX_W'(1);
                nxt.hdr_first = eff_first;
                if (!eff_first && eff_idx == HDR_SEQ_IDX)
                begin
                    nxt.sequence_count = st.sequence_count + 8'd1;
                end
            end
            PH_DATA:
            begin
                res.emit        = 1'b1;
                res.report_byte = item.data_byte;
                if (item.last_of_message)
                begin
                    nxt.message_started = 1'b0;
                    nxt.sequence_count  = 8'h00;
                    res.message_end     = rend;
                    res.done            = rend;
                    nxt.phase           = PH_PAD;
                end
                else
                begin
                    res.done = 1'b1;
                end
            end
            PH_PAD:
            begin
                res.emit        = 1'b1;
                res.report_byte = 8'h00;
                res.message_end = rend;
                res.done        = rend;
                nxt.phase       = PH_PAD;
            end
            PH_IDLE:
            begin
                res.done = (st.phase == PH_NEW);
            end
            default:
            begin
                res.done = 1'b0;
            end
        endcase

        if (res.emit)
        begin
            nxt.report_offset = rend ? '0 : cur_off + OFFSET_W'(1);
        end
    end

endmodule

[rtl/core/hid_message_report_framer.sv]
// Top level of the HID message report framer: item register, framing state,
// output register and handshakes. Depends on hmrf_pkg and hmrf_step.
// Each accepted item yields zero to REPORT_BYTES report bytes, one per cycle
// while the receiver does not stall; a byte outside any open message yields none.
// A steady stream of payload bytes in the middle of a report runs at one byte
// per cycle while the receiver keeps up. An item that opens a report first emits
// its header bytes (seven for the first report, five for a continuation), and a
// final byte is followed by the padding bytes of its report; the input is stalled
// meanwhile. The single byte sequencer in hmrf_step emits these bytes in order.
// The output register holds one byte, so while the receiver stalls a waiting byte
// the sequencer and the input wait with it.
`timescale 1ns / 1ps

module hid_message_report_framer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_of_message,
    input  logic        last_of_message,
    input  logic        empty_message,
    input  logic [31:0] channel_id,
    input  logic [7:0]  command,
    input  logic [15:0] message_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  report_byte,
    output logic        report_end,
    output logic        message_end
);
    import hmrf_pkg::*;

    item_t        item_reg;
    frame_state_t state_reg;
    frame_state_t state_next;
    frame_state_t step_state;
    step_out_t    step_res;
    logic         out_valid_reg;
    logic [7:0]   report_byte_reg;
    logic         report_end_reg;
    logic         message_end_reg;
    logic         out_free;
    logic         advance;
    logic         in_take;

    hmrf_step u_step (
        .item (item_reg),
        .st   (state_reg),
        .res  (step_res),
        .nxt  (step_state)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = (state_reg.phase != PH_IDLE) && (!step_res.emit || out_free);
    assign in_stall = (state_reg.phase != PH_IDLE) && !(advance && step_res.done);
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        if (advance)
        begin
            state_next = step_state;
        end
        // A finished item hands over to the next one in the same cycle.
        if (in_take)
        begin
            state_next.phase = PH_NEW;
        end
        else if (advance && step_res.done)
        begin
            state_next.phase = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.data_byte        <= data_byte;
            item_reg.first_of_message <= first_of_message;
            item_reg.last_of_message  <= last_of_message;
            item_reg.empty_message    <= empty_message;
            item_reg.channel_id       <= channel_id;
            item_reg.command          <= command;
            item_reg.message_length   <= message_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && step_res.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_res.emit)
        begin
            report_byte_reg <= step_res.report_byte;
            report_end_reg  <= step_res.report_end;
            message_end_reg <= step_res.message_end;
        end
    end

    assign out_valid   = out_valid_reg;
    assign report_byte = report_byte_reg;
    assign report_end  = report_end_reg;
    assign message_end = message_end_reg;

`ifndef SYNTH
    // The end of a message always closes a report.
    a_msg_end_closes_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_end |-> report_end)
        else $error("message_end without report_end");

    // With no message open and nothing in hand, no report is left half built.
    a_closed_when_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_IDLE) && !state_reg.message_started
            |-> state_reg.report_offset == '0)
        else $error("report left open outside a message");

    // An accepted transfer is decoded in the following cycle.
    a_take_decodes: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> state_reg.phase == PH_NEW)
        else $error("accepted item not taken into the sequencer");
`endif

endmodule

[dv/tb.sv]
// Self-checking testbench for hid_message_report_framer: a clocked driver and monitor
// check every report byte against an in-bench framing model fed with the same items.
// Depends on hmrf_pkg and the framer RTL only.
`timescale 1ns / 1ps

module tb;
    import hmrf_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        logic [7:0] value;
        logic       rend;
        logic       mend;
    } report_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        first_of_message = 1'b0;
    logic        last_of_message = 1'b0;
    logic        empty_message = 1'b0;
    logic [31:0] channel_id = '0;
    logic [7:0]  command = '0;
    logic [15:0] message_length = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  report_byte;
    logic        report_end;
    logic        message_end;

    item_t        message_items[$];
    report_beat_t framed_bytes[$];

    // Framing state mirrored from the block.
    int          frm_offset;
    bit          frm_open;
    logic [7:0]  frm_seq;
    logic [31:0] frm_channel;
    logic [7:0]  frm_command;
    logic [15:0] frm_length;

    bit  in_fired;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  long_hold_req;
    int  long_hold_left;
    int  failures;
    int  cycle_count;
    int  items_queued;

    hid_message_report_framer u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .first_of_message (first_of_message),
        .last_of_message  (last_of_message),
        .empty_message    (empty_message),
        .channel_id       (channel_id),
        .command          (command),
        .message_length   (message_length),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .report_byte      (report_byte),
        .report_end       (report_end),
        .message_end      (message_end)
    );

    always #4 clk = ~clk;

    task automatic put_report_byte(input logic [7:0] b);
        report_beat_t beat;
        beat.value = b;
        beat.rend  = 1'b0;
        beat.mend  = 1'b0;
        frm_offset++;
        if (frm_offset >= REPORT_BYTES)
        begin
            beat.rend  = 1'b1;
            frm_offset = 0;
        end
        framed_bytes.push_back(beat);
    endtask

    task automatic put_channel();
        for (int k = 0; k < 4; k++)
        begin
            put_report_byte(frm_channel[8*k +: 8]);
        end
    endtask

    task automatic put_first_header();
        put_channel();
        put_report_byte(frm_command);
        put_report_byte(frm_length[15:8]);
        put_report_byte(frm_length[7:0]);
    endtask

    // Pads the open report with zeros and marks the final byte as the message end.
    task automatic close_message();
        while (frm_offset != 0)
        begin
            put_report_byte(8'h00);
        end
        framed_bytes[framed_bytes.size() - 1].mend = 1'b1;
    endtask

    task automatic frame_item(input item_t it);
        if (it.empty_message)
        begin
            frm_channel = it.channel_id;
            frm_command = it.command;
            frm_length  = it.message_length;
            frm_offset  = 0;
            frm_seq     = '0;
            frm_open    = 1'b0;
            put_first_header();
            close_message();
        end
        else if (it.first_of_message || frm_open)
        begin
            if (it.first_of_message)
            begin
                frm_channel = it.channel_id;
                frm_command = it.command;
                frm_length  = it.message_length;
                frm_offset  = 0;
                frm_seq     = '0;
                frm_open    = 1'b1;
                put_first_header();
            end
            else if (frm_offset == 0)
            begin
                put_channel();
                put_report_byte(frm_seq);
                frm_seq = frm_seq + 8'd1;
            end
            put_report_byte(it.data_byte);
            if (it.last_of_message)
            begin
                close_message();
                frm_open = 1'b0;
                frm_seq  = '0;
            end
        end
    endtask

    function automatic item_t make_item(input logic [7:0] d, input logic f, input logic l,
                                        input logic e, input logic [31:0] ch,
                                        input logic [7:0] cmd, input logic [15:0] len);
        item_t it;
        it.data_byte        = d;
        it.first_of_message = f;
        it.last_of_message  = l;
        it.empty_message    = e;
        it.channel_id       = ch;
        it.command          = cmd;
        it.message_length   = len;
        return it;
    endfunction

    function automatic item_t random_item();
        return make_item(8'($urandom), 1'b0, 1'b0, 1'b0, $urandom, 8'($urandom),
                         16'($urandom));
    endfunction

    // A message of n payload bytes; without close it is left open and later abandoned.
    task automatic queue_message(input int n, input bit close);
        item_t it;
        for (int k = 0; k < n; k++)
        begin
            it = random_item();
            it.first_of_message = (k == 0);
            it.last_of_message  = close && (k == n - 1);
            if (k == 0 && $urandom_range(0, 3) != 0)
                it.message_length = n[15:0];
            message_items.push_back(it);
            items_queued++;
        end
    endtask

    task automatic queue_random_phase(input int count);
        item_t it;
        int    pick;
        int    target;
        target = items_queued + count;
        while (items_queued < target)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                it = random_item();
                it.empty_message    = 1'b1;
                it.first_of_message = 1'($urandom);
                it.last_of_message  = 1'($urandom);
                message_items.push_back(it);
                items_queued++;
            end
            else if (pick == 1)
            begin
                // Byte with no first mark: ignored unless a message is left open; not counted.
                it = random_item();
                it.last_of_message = 1'($urandom);
                message_items.push_back(it);
            end
            else if (pick == 2)
            begin
                queue_message($urandom_range(1, 10), 1'b0);
            end
            else
            begin
                case ($urandom_range(0, 15))
                    0:       queue_message(REPORT_BYTES - 7, 1'b1);
                    1:       queue_message(REPORT_BYTES - 6, 1'b1);
                    2:       queue_message(2 * REPORT_BYTES - 12, 1'b1);
                    3:       queue_message(REPORT_BYTES - 2, 1'b1);
                    default: queue_message($urandom_range(1, 12), 1'b1);
                endcase
            end
        end
    endtask

    task automatic wait_for_drain();
        while (message_items.size() != 0 || in_valid || framed_bytes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Driver: a payload is held until its transfer completes.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fired)
        begin
            in_fired = 1'b0;
            if (message_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                item_t it;
                it = message_items.pop_front();
                data_byte        <= it.data_byte;
                first_of_message <= it.first_of_message;
                last_of_message  <= it.last_of_message;
                empty_message    <= it.empty_message;
                channel_id       <= it.channel_id;
                command          <= it.command;
                message_length   <= it.message_length;
                in_valid         <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off counted here.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (long_hold_req)
            begin
                long_hold_left = LONG_HOLD;
                long_hold_req  = 1'b0;
            end
            if (long_hold_left > 0)
            begin
                long_hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Monitor: checks output transfers and predicts on input transfers.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (framed_bytes.size() == 0)
                begin
                    $display("%0t: unexpected report byte %02h end %0b msg_end %0b",
                             $time, report_byte, report_end, message_end);
                    failures++;
                end
                else
                begin
                    report_beat_t want;
                    want = framed_bytes.pop_front();
                    if (report_byte !== want.value)
                    begin
                        $display("%0t: report_byte expected %02h actual %02h",
                                 $time, want.value, report_byte);
                        failures++;
                    end
                    if (report_end !== want.rend)
                    begin
                        $display("%0t: report_end expected %0b actual %0b",
                                 $time, want.rend, report_end);
                        failures++;
                    end
                    if (message_end !== want.mend)
                    begin
                        $display("%0t: message_end expected %0b actual %0b",
                                 $time, want.mend, message_end);
                        failures++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                frame_item(make_item(data_byte, first_of_message, last_of_message,
                                     empty_message, channel_id, command, message_length));
                in_fired = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("hid_message_report_framer: mismatch");
            $finish;
        end
    end

    initial
    begin
        frm_offset    = 0;
        frm_open      = 1'b0;
        frm_seq       = '0;
        frm_channel   = '0;
        frm_command   = '0;
        frm_length    = '0;
        send_idle_pct = 13;
        recv_idle_pct = 64;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: field extremes, stray bytes, empty and overlapping messages.
        message_items.push_back(make_item(8'hff, 1'b0, 1'b0, 1'b0, '1, '1, '1));
        message_items.push_back(make_item(8'hff, 1'b0, 1'b1, 1'b0, '1, '1, '1));
        message_items.push_back(make_item(8'h00, 1'b0, 1'b0, 1'b1, '1, '1, '1));
        message_items.push_back(make_item(8'hff, 1'b0, 1'b0, 1'b1, '0, '0, '0));
        message_items.push_back(make_item(8'hff, 1'b1, 1'b1, 1'b0, '0, '0, 16'd1));
        message_items.push_back(make_item(8'h00, 1'b1, 1'b1, 1'b0, '1, '1, 16'd300));
        // A new first abandons the open report.
        message_items.push_back(make_item(8'h5a, 1'b1, 1'b0, 1'b0, 32'h12345678, 8'h90, 16'd3));
        message_items.push_back(make_item(8'ha5, 1'b0, 1'b0, 1'b0, '1, '1, '1));
        message_items.push_back(make_item(8'h3c, 1'b1, 1'b0, 1'b0, 32'h87654321, 8'h11, 16'd2));
        message_items.push_back(make_item(8'hc3, 1'b0, 1'b1, 1'b0, '0, '0, '0));
        // An empty message in the middle of an open one.
        message_items.push_back(make_item(8'h01, 1'b1, 1'b0, 1'b0, 32'hdeadbeef, 8'h83, 16'd2));
        message_items.push_back(make_item(8'h02, 1'b0, 1'b0, 1'b0, '0, '0, '0));
        message_items.push_back(make_item(8'h03, 1'b0, 1'b0, 1'b1, 32'h0badf00d, 8'h81, 16'd0));
        message_items.push_back(make_item(8'h04, 1'b0, 1'b1, 1'b0, '0, '0, '0));
        // Every mark at once: the empty mark wins.
        message_items.push_back(make_item(8'h77, 1'b1, 1'b1, 1'b1, 32'h00ff00ff, 8'h80, 16'hff00));
        message_items.push_back(make_item(8'h88, 1'b0, 1'b1, 1'b0, '1, '1, '1));
        items_queued = 16;
        queue_message(4, 1'b1);
        wait_for_drain();

        queue_random_phase(65);
        wait_for_drain();

        send_idle_pct = 64;
        recv_idle_pct = 13;
        queue_random_phase(65);
        wait_for_drain();

        // Neither side idles; a long hold-off fills the block while items keep coming.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold_req = 1'b1;
        queue_message(2 * REPORT_BYTES - 12, 1'b1);
        queue_random_phase(60);
        wait_for_drain();

        repeat (3 * REPORT_BYTES) @(posedge clk);
        if (failures == 0 && framed_bytes.size() == 0)
            $display("hid_message_report_framer: match");
        else
            $display("hid_message_report_framer: mismatch");
        $finish;
    end

endmodule
